FILE: rtl/rbdm_pkg.sv
// ----------------------------------------------------------------------------
// rbdm_pkg
// Shared widths, codes, reset values and window types of the RAW10 demosaic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbdm_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int DEST_W    = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W   = 3;
  // common width for size compares and coordinate math
  localparam int EXT_W     = 14;

  // input item kinds
  localparam logic KIND_RAW   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // byte phase of the packed low-bit byte
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT     = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // smallest frame size after clamping
  localparam logic [EXT_W-1:0] MIN_DIM = 14'd2;

  typedef logic [PIX_W-1:0] pix_t;
  // one row of three samples: 0 left, 1 centre, 2 right
  typedef pix_t [2:0] row3_t;
  // window: [column oldest..newest][row top, mid, bottom]
  typedef pix_t [2:0][2:0] win_t;

  // neighborhood handed to the interpolator, edges already mirrored
  typedef struct packed {
    row3_t top;
    row3_t mid;
    row3_t bot;
    logic  x_odd;
    logic  y_odd;
  } nbhd_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

endpackage

`default_nettype wire

FILE: rtl/rbdm_if.sv
// ----------------------------------------------------------------------------
// rbdm_in_if / rbdm_out_if
// Valid/ready channels for raw bytes in and RGB pixels out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rbdm_in_if import rbdm_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  pix_t raw_byte;

  modport source (output valid, kind, raw_byte, input ready);
  modport sink   (input valid, kind, raw_byte, output ready);
endinterface

interface rbdm_out_if import rbdm_pkg::*; ();
  logic              valid;
  logic              ready;
  pix_t              red;
  pix_t              green;
  pix_t              blue;
  logic [DEST_W-1:0] dest_col;
  logic [DEST_W-1:0] dest_row;
  logic              frame_done;
  logic              run_last;

  modport source (output valid, red, green, blue, dest_col, dest_row, frame_done, run_last,
                  input ready);
  modport sink   (input valid, red, green, blue, dest_col, dest_row, frame_done, run_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/rbdm_line_store.sv
// ----------------------------------------------------------------------------
// rbdm_line_store
// One line of pixels: one write port, two registered read ports, write-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbdm_line_store import rbdm_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire pix_t                wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  rd0_addr,
  input  wire [$clog2(DEPTH)-1:0]  rd1_addr,
  output pix_t                     rd0_data,
  output pix_t                     rd1_data
);

  pix_t store_r [DEPTH];
  pix_t rd0_r;
  pix_t rd1_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // read ports, a write in the same cycle to the same entry is passed through
  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r <= (we && (waddr == rd0_addr)) ? wdata : store_r[rd0_addr];
      rd1_r <= (we && (waddr == rd1_addr)) ? wdata : store_r[rd1_addr];
    end
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule

`default_nettype wire

FILE: rtl/rbdm_demosaic.sv
// ----------------------------------------------------------------------------
// rbdm_demosaic
// Bilinear BGGR interpolation of one pixel from its mirrored 3x3 neighborhood
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbdm_demosaic import rbdm_pkg::*; (
  input  wire nbhd_t nb,
  output rgb_t       rgb
);

  logic [PIX_W:0]   sum_h;
  logic [PIX_W:0]   sum_v;
  logic [PIX_W+1:0] sum_d;
  logic [PIX_W:0]   sum_g;
  pix_t             hn;
  pix_t             vn;
  pix_t             di;
  pix_t             g_avg;
  pix_t             ctr;

  // truncating neighbor averages
  assign sum_h = {1'b0, nb.mid[0]} + {1'b0, nb.mid[2]};
  assign sum_v = {1'b0, nb.top[1]} + {1'b0, nb.bot[1]};
  assign sum_d = {2'b00, nb.top[0]} + {2'b00, nb.top[2]}
               + {2'b00, nb.bot[0]} + {2'b00, nb.bot[2]};
  assign hn    = sum_h[PIX_W:1];
  assign vn    = sum_v[PIX_W:1];
  assign di    = sum_d[PIX_W+1:2];
  assign sum_g = {1'b0, vn} + {1'b0, hn};
  assign g_avg = sum_g[PIX_W:1];
  assign ctr   = nb.mid[1];

  // site selection: blue at even/even, red at odd/odd, green elsewhere
  always_comb begin
    if (nb.x_odd ^ nb.y_odd) begin
      rgb.green = ctr;
      if (nb.y_odd) begin
        rgb.red  = hn;
        rgb.blue = vn;
      end else begin
        rgb.red  = vn;
        rgb.blue = hn;
      end
    end else if (nb.y_odd) begin
      rgb.red   = ctr;
      rgb.green = g_avg;
      rgb.blue  = di;
    end else begin
      rgb.blue  = ctr;
      rgb.green = g_avg;
      rgb.red   = di;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/raw10_bayer_demosaic_rgb_core.sv
// ----------------------------------------------------------------------------
// raw10_bayer_demosaic_rgb_core
// Packed RAW10 BGGR stream to RGB pixels with destination coordinates
// ----------------------------------------------------------------------------
//
//  port     dir   handshake      carries
//  in_ch    in    valid/ready    kind, raw_byte (packed stream or drain tick)
//  out_ch   out   valid/ready    red, green, blue, dest_col, dest_row,
//                                frame_done, run_last
//  cfg_*    in    cfg_we only    frame_width, frame_height, portrait
//
//  One item is taken per cycle while stage 1 is not stalled. The last pixel
//  byte of a line below the first yields two pixels and holds the input until
//  the second has been loaded into the output register. At a transfer the line
//  store read ports and stage 1 register the item, then the interpolator feeds
//  the output register from them when stage 1 fires.
//  Line stores are read at transfer and written back when stage 1 fires; a read of
//  the entry being written gets the new data. The stores need no clearing pass.
//  A full output register stalls stage 1, which drops in_ch.ready.
//  Synchronous active-low reset clears counters, window and valid flags.
//
`timescale 1ns / 1ps
`default_nettype none

module raw10_bayer_demosaic_rgb_core import rbdm_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  rbdm_in_if.sink              in_ch,
  rbdm_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // configuration
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             portrait_r;
  logic             cfg_hit;
  logic [EXT_W-1:0] w_e;
  logic [EXT_W-1:0] h_e;
  logic [EXT_W-1:0] fw_e;
  logic [EXT_W-1:0] fh_e;

  // stream position
  logic [PHASE_W-1:0] byte_phase_r, byte_phase_nxt;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic               frame_full_r, frame_full_nxt;

  // transfer decode
  logic             in_fire;
  logic             is_drain;
  logic             phase_drop;
  logic             pix_active;
  logic             drain_active;
  logic             drain_done;
  logic             x_last;
  logic             row_last;
  logic             s1_load;
  logic [EXT_W-1:0] x_e;
  logic [EXT_W-1:0] y_e;
  logic [EXT_W-1:0] oc_e;
  logic [COL_W-1:0] rd0_addr;
  logic [COL_W-1:0] rd1_addr;

  // stage 1
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_second_r, s1_second_nxt;
  logic             s1_pixel_r;
  pix_t             s1_px_r;
  logic [COL_W-1:0] s1_x_r;
  logic [ROW_W-1:0] s1_y_r;
  logic             s1_main_r;
  logic             s1_edge_r;
  logic             s1_top_mir_r;
  logic             s1_left_mir_r;
  logic             s1_x0_r;
  logic             s1_done_r;
  logic             s1_has_res;
  logic             s1_two;
  logic             s1_fire;
  logic             s1_retire;
  logic             s1_first;
  logic             out_free;

  // line stores and window
  logic mem_we;
  pix_t a_rd0, a_rd1, b_rd0, b_rd1;
  pix_t sav_a_r, sav_b_r;
  win_t win_r;
  win_t win_shift;
  win_t win_src;
  logic [1:0] topi, lidx, cidx, ridx;
  pix_t l_a, l_b;

  // result assembly
  nbhd_t            nb;
  rgb_t             rgb;
  logic [EXT_W-1:0] ox_e;
  logic [EXT_W-1:0] oy_e;
  logic [EXT_W-1:0] dr_e;
  logic             out_valid_r;
  rgb_t             out_rgb_r;
  logic [DEST_W-1:0] out_dc_r;
  logic [DEST_W-1:0] out_dr_r;
  logic             out_done_r;
  logic             out_last_r;

  // effective frame size, clamped to MIN_DIM and to MAX_WIDTH / MAX_HEIGHT
  assign fw_e = EXT_W'(frame_width_r);
  assign fh_e = EXT_W'(frame_height_r);
  always_comb begin
    w_e = fw_e;
    if (fw_e < MIN_DIM) w_e = MIN_DIM;
    if (fw_e > EXT_W'(MAX_WIDTH)) w_e = EXT_W'(MAX_WIDTH);
    h_e = fh_e;
    if (fh_e < MIN_DIM) h_e = MIN_DIM;
    if (fh_e > EXT_W'(MAX_HEIGHT)) h_e = EXT_W'(MAX_HEIGHT);
  end

  // configuration writes
  assign cfg_hit = cfg_we && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT,
                                                REG_PORTRAIT});
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      portrait_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_PORTRAIT:     portrait_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input transfer decode
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_drain     = (in_ch.kind == KIND_DRAIN);
  assign x_e          = EXT_W'(in_col_r);
  assign y_e          = EXT_W'(in_row_r);
  assign oc_e         = EXT_W'(out_col_r);
  assign phase_drop   = (byte_phase_r >= PHASE_LAST);
  assign x_last       = (x_e == w_e - 1'b1);
  assign row_last     = (y_e + 1'b1 >= h_e);
  assign pix_active   = !is_drain && !phase_drop && !frame_full_r && (x_e < w_e);
  assign drain_active = is_drain && frame_full_r && (oc_e < w_e);
  assign drain_done   = (oc_e == w_e - 1'b1);
  assign s1_load      = in_fire && (pix_active || drain_active);

  // stream position next state
  always_comb begin
    byte_phase_nxt = byte_phase_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    out_col_nxt    = out_col_r;
    frame_full_nxt = frame_full_r;
    if (cfg_hit) begin
      byte_phase_nxt = '0;
      in_col_nxt     = '0;
      in_row_nxt     = '0;
      out_col_nxt    = '0;
      frame_full_nxt = 1'b0;
    end else if (in_fire) begin
      if (!is_drain) begin
        byte_phase_nxt = phase_drop ? '0 : byte_phase_r + 1'b1;
        if (pix_active) begin
          if (x_last) begin
            in_col_nxt = '0;
            if (row_last) begin
              frame_full_nxt = 1'b1;
              byte_phase_nxt = PHASE_LAST;
              out_col_nxt    = '0;
            end else begin
              in_row_nxt = in_row_r + 1'b1;
            end
          end else begin
            in_col_nxt = in_col_r + 1'b1;
          end
        end
      end else if (drain_active) begin
        if (drain_done) begin
          in_col_nxt     = '0;
          in_row_nxt     = '0;
          out_col_nxt    = '0;
          frame_full_nxt = 1'b0;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_phase_r <= '0;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      frame_full_r <= 1'b0;
    end else begin
      byte_phase_r <= byte_phase_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      out_col_r    <= out_col_nxt;
      frame_full_r <= frame_full_nxt;
    end
  end

  // line store read addresses: centre column, and right neighbor for drain (left one at the last column)
  assign rd0_addr = is_drain ? out_col_r : in_col_r;
  assign rd1_addr = drain_done ? out_col_r - 1'b1 : out_col_r + 1'b1;

  // stage 1 control
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_has_res = !s1_pixel_r || s1_main_r;
  assign s1_two     = s1_pixel_r && s1_edge_r && !s1_second_r;
  assign s1_fire    = s1_valid_r && (!s1_has_res || out_free);
  assign s1_retire  = s1_fire && !s1_two;
  assign s1_first   = s1_fire && !s1_second_r;
  assign in_ch.ready = !s1_valid_r || s1_retire;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_second_nxt = s1_second_r;
    if (s1_retire) begin
      s1_valid_nxt  = 1'b0;
      s1_second_nxt = 1'b0;
    end else if (s1_fire && s1_two) begin
      s1_second_nxt = 1'b1;
    end
    if (s1_load) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_second_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_second_r <= s1_second_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pixel_r    <= !is_drain;
      s1_px_r       <= in_ch.raw_byte;
      s1_x_r        <= is_drain ? out_col_r : in_col_r;
      s1_y_r        <= in_row_r;
      s1_main_r     <= (in_row_r != '0) && (in_col_r != '0);
      s1_edge_r     <= (in_row_r != '0) && x_last;
      s1_top_mir_r  <= (y_e == EXT_W'(1));
      s1_left_mir_r <= (x_e == EXT_W'(1));
      s1_x0_r       <= (out_col_r == '0);
      s1_done_r     <= drain_done;
    end
  end

  // line stores: a holds the newest row, b the row above it
  assign mem_we = s1_first && s1_pixel_r;

  rbdm_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store_a (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (s1_x_r),
    .wdata    (s1_px_r),
    .re       (in_fire),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd0_data (a_rd0),
    .rd1_data (a_rd1)
  );

  rbdm_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store_b (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (s1_x_r),
    .wdata    (a_rd0),
    .re       (in_fire),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd0_data (b_rd0),
    .rd1_data (b_rd1)
  );

  // window shift with the new column
  always_comb begin
    win_shift[0]    = win_r[1];
    win_shift[1]    = win_r[2];
    win_shift[2][0] = b_rd0;
    win_shift[2][1] = a_rd0;
    win_shift[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (mem_we) begin
      win_r <= win_shift;
    end
  end

  // drain keeps the previous centre column as the next left neighbor
  always_ff @(posedge clk) begin
    if (s1_fire && !s1_pixel_r) begin
      sav_a_r <= a_rd0;
      sav_b_r <= b_rd0;
    end
  end

  // neighborhood select with mirroring at the edges
  assign win_src = s1_second_r ? win_r : win_shift;
  assign topi    = s1_top_mir_r ? 2'd2 : 2'd0;
  assign l_a     = s1_x0_r ? a_rd1 : sav_a_r;
  assign l_b     = s1_x0_r ? b_rd1 : sav_b_r;

  always_comb begin
    if (s1_second_r) begin
      lidx = 2'd1;
      cidx = 2'd2;
      ridx = 2'd1;
    end else begin
      lidx = s1_left_mir_r ? 2'd2 : 2'd0;
      cidx = 2'd1;
      ridx = 2'd2;
    end
  end

  always_comb begin
    if (s1_pixel_r) begin
      nb.top[0] = win_src[lidx][topi];
      nb.top[1] = win_src[cidx][topi];
      nb.top[2] = win_src[ridx][topi];
      nb.mid[0] = win_src[lidx][1];
      nb.mid[1] = win_src[cidx][1];
      nb.mid[2] = win_src[ridx][1];
      nb.bot[0] = win_src[lidx][2];
      nb.bot[1] = win_src[cidx][2];
      nb.bot[2] = win_src[ridx][2];
      ox_e      = s1_second_r ? EXT_W'(s1_x_r) : EXT_W'(s1_x_r) - 1'b1;
      oy_e      = EXT_W'(s1_y_r) - 1'b1;
    end else begin
      nb.top[0] = l_b;
      nb.top[1] = b_rd0;
      nb.top[2] = b_rd1;
      nb.mid[0] = l_a;
      nb.mid[1] = a_rd0;
      nb.mid[2] = a_rd1;
      nb.bot    = nb.top;
      ox_e      = EXT_W'(s1_x_r);
      oy_e      = h_e - 1'b1;
    end
    nb.x_odd = ox_e[0];
    nb.y_odd = oy_e[0];
  end

  rbdm_demosaic u_demosaic (
    .nb  (nb),
    .rgb (rgb)
  );

  assign dr_e = w_e - 1'b1 - ox_e;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      out_rgb_r  <= rgb;
      out_dc_r   <= portrait_r ? oy_e[DEST_W-1:0] : ox_e[DEST_W-1:0];
      out_dr_r   <= portrait_r ? dr_e[DEST_W-1:0] : oy_e[DEST_W-1:0];
      out_done_r <= !s1_pixel_r && s1_done_r;
      out_last_r <= !s1_two;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = out_rgb_r.red;
  assign out_ch.green      = out_rgb_r.green;
  assign out_ch.blue       = out_rgb_r.blue;
  assign out_ch.dest_col   = out_dc_r;
  assign out_ch.dest_row   = out_dr_r;
  assign out_ch.frame_done = out_done_r;
  assign out_ch.run_last   = out_last_r;

endmodule

`default_nettype wire

FILE: verif/raw10_bayer_demosaic_rgb_core_tb.sv
// ----------------------------------------------------------------------------
// raw10_bayer_demosaic_rgb_core_tb
// Self-checking bench for the RAW10 BGGR demosaic core: packed bytes and
// drain ticks go in under random idling, every RGB pixel coming out is
// compared field by field against a cycle-free model of the window pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raw10_bayer_demosaic_rgb_core_tb;
  import rbdm_pkg::*;

  localparam int STORE_DEPTH       = 4096;
  localparam int MAX_LINES         = 4096;
  localparam int RESET_CYCLES      = 7;
  localparam int SETTLE_CYCLES     = 6;
  localparam int WATCHDOG_LIMIT    = 1000;
  localparam int RANDOM_ITEMS      = 200;
  localparam int RESET_PROBE_BYTES = 20;
  localparam int LIMIT_PROBE_BYTES = 30;
  localparam int FILL_RANDOM       = -1;
  // index that maps to no register; a write there must not disturb the frame
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    pix_t              red;
    pix_t              green;
    pix_t              blue;
    logic [DEST_W-1:0] dest_col;
    logic [DEST_W-1:0] dest_row;
    logic              frame_done;
    logic              run_last;
  } rgb_pixel_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  rbdm_in_if  in_ch ();
  rbdm_out_if out_ch ();

  raw10_bayer_demosaic_rgb_core #(
    .MAX_WIDTH (STORE_DEPTH),
    .MAX_HEIGHT(MAX_LINES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state: registers, line stores, window and stream counters
  logic [CFG_W-1:0] frame_w_reg   = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] frame_h_reg   = FRAME_HEIGHT_RST;
  logic             portrait_reg  = 1'b0;
  pix_t             newest_row [STORE_DEPTH] = '{default: '0};
  pix_t             prior_row  [STORE_DEPTH] = '{default: '0};
  pix_t             win [3][3]   = '{default: '{default: '0}};
  int unsigned      byte_phase   = 0;
  int unsigned      src_col      = 0;
  int unsigned      src_row      = 0;
  int unsigned      flush_col    = 0;

  rgb_pixel_t  pending_pixels[$];
  rgb_pixel_t  want_px;
  int unsigned pixel_errors = 0;
  int unsigned items_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap       = 0;
  bit          in_busy      = 1'b0;
  bit          stall_mode   = 1'b1;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit frame_complete();
    return src_row >= clamp_dim(frame_h_reg, MAX_LINES);
  endfunction

  function automatic row3_t trio(pix_t l, pix_t c, pix_t r);
    return {r, c, l};
  endfunction

  // bilinear interpolation of one BGGR site plus destination mapping
  function automatic rgb_pixel_t interp(row3_t t, row3_t m, row3_t b, int unsigned x,
                                        int unsigned y, int unsigned w, logic done);
    int unsigned hn, vn, di, r, g, bl, dc, dr;
    rgb_pixel_t  p;
    hn = (m[0] + m[2]) / 2;
    vn = (t[1] + b[1]) / 2;
    di = (t[0] + t[2] + b[0] + b[2]) / 4;
    if (((x + y) & 1) != 0) begin
      g = m[1];
      if ((y & 1) != 0) begin
        r  = hn;
        bl = vn;
      end else begin
        r  = vn;
        bl = hn;
      end
    end else if ((y & 1) != 0) begin
      r  = m[1];
      g  = (vn + hn) / 2;
      bl = di;
    end else begin
      bl = m[1];
      g  = (vn + hn) / 2;
      r  = di;
    end
    if (portrait_reg) begin
      dc = y;
      dr = w - 1 - x;
    end else begin
      dc = x;
      dr = y;
    end
    p.red        = r[PIX_W-1:0];
    p.green      = g[PIX_W-1:0];
    p.blue       = bl[PIX_W-1:0];
    p.dest_col   = dc[DEST_W-1:0];
    p.dest_row   = dr[DEST_W-1:0];
    p.frame_done = done;
    p.run_last   = 1'b0;
    return p;
  endfunction

  // advance the model by one accepted item and queue the pixels it yields
  function automatic void predict_pixels(logic kind, pix_t data);
    int unsigned w, h, ph, x, y, lc, topi, nres, l, r;
    pix_t        up1, up2;
    row3_t       t, m, b;
    logic        done;
    rgb_pixel_t  res [2];
    w    = clamp_dim(frame_w_reg, STORE_DEPTH);
    h    = clamp_dim(frame_h_reg, MAX_LINES);
    nres = 0;
    if (kind == KIND_RAW) begin
      ph = byte_phase;
      x  = src_col;
      y  = src_row;
      byte_phase = (ph >= PHASE_LAST) ? 0 : ph + 1;
      if (ph < PHASE_LAST && y < h && x < w) begin
        // line stores shift down one row, window shifts left one column
        up2 = prior_row[x];
        up1 = newest_row[x];
        prior_row[x]  = up1;
        newest_row[x] = data;
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = up2;
        win[2][1] = up1;
        win[2][2] = data;
        if (y >= 1) begin
          topi = (y == 1) ? 2 : 0;
          if (x >= 1) begin
            lc = (x == 1) ? 2 : 0;
            t = trio(win[lc][topi], win[1][topi], win[2][topi]);
            m = trio(win[lc][1], win[1][1], win[2][1]);
            b = trio(win[lc][2], win[1][2], win[2][2]);
            res[nres] = interp(t, m, b, x - 1, y - 1, w, 1'b0);
            nres++;
            flush_col = x;
          end
          // right edge: the pixel under the newest column, mirrored
          if (x == w - 1) begin
            t = trio(win[1][topi], win[2][topi], win[1][topi]);
            m = trio(win[1][1], win[2][1], win[1][1]);
            b = trio(win[1][2], win[2][2], win[1][2]);
            res[nres] = interp(t, m, b, x, y - 1, w, 1'b0);
            nres++;
            flush_col = 0;
          end
        end
        x++;
        if (x >= w) begin
          x = 0;
          y++;
          if (y >= h) begin
            y          = h;
            byte_phase = PHASE_LAST;
            flush_col  = 0;
          end
        end
        src_col = x;
        src_row = y;
      end
    end else begin
      // drain tick: last row, bottom neighbours mirrored from the top
      x = flush_col;
      if (src_row >= h && x < w) begin
        l = (x > 0) ? x - 1 : x + 1;
        r = (x < w - 1) ? x + 1 : x - 1;
        t = trio(prior_row[l], prior_row[x], prior_row[r]);
        m = trio(newest_row[l], newest_row[x], newest_row[r]);
        done = (x == w - 1);
        res[0] = interp(t, m, t, x, h - 1, w, done);
        nres = 1;
        if (done) begin
          src_col   = 0;
          src_row   = 0;
          flush_col = 0;
        end else begin
          flush_col = x + 1;
        end
      end
    end
    if (nres > 0) res[nres-1].run_last = 1'b1;
    for (int i = 0; i < nres; i++) pending_pixels.push_back(res[i]);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) frame_w_reg = val;
    else if (idx == REG_FRAME_HEIGHT) frame_h_reg = val;
    else if (idx == REG_PORTRAIT) portrait_reg = val[0];
    else return;
    // any listed register write aborts the frame in progress
    byte_phase = 0;
    src_col    = 0;
    src_row    = 0;
    flush_col  = 0;
  endfunction

  // one input transfer; valid stays high when the next gap is zero
  task automatic send_item(logic kind, pix_t data);
    if (in_gap > 0) repeat (in_gap) @(posedge clk);
    in_ch.kind     <= kind;
    in_ch.raw_byte <= data;
    in_ch.valid    <= 1'b1;
    in_busy = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_pixels(kind, data);
    items_taken++;
    in_gap = stall_mode ? $urandom_range(0, 19) : 0;
    if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  // drop valid and wait until the core has nothing left in flight
  task automatic settle();
    if (in_busy) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // well-formed frame then drain; noisy adds stray drains and ignored bytes
  task automatic run_frame(int fill, bit noisy);
    while (!frame_complete()) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_item(KIND_DRAIN, PIX_W'($urandom_range(0, 255)));
      send_item(KIND_RAW, (fill < 0) ? PIX_W'($urandom_range(0, 255)) : PIX_W'(fill));
    end
    if (noisy) repeat ($urandom_range(0, 2)) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    while (frame_complete()) send_item(KIND_DRAIN, PIX_W'($urandom_range(0, 255)));
    if (noisy && $urandom_range(0, 3) == 0) send_item(KIND_DRAIN, PIX_W'($urandom_range(0, 255)));
  endtask

  // reset sizes: the first bytes of a 640 pixel line give no pixel
  task automatic test_reset_values();
    repeat (RESET_PROBE_BYTES) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
  endtask

  // small 4x2 frame at both orientations and flat fills
  task automatic test_min_frames();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_PORTRAIT, 13'd0);
    run_frame(8'hFF, 1'b0);
    write_reg(REG_PORTRAIT, 13'd1);
    run_frame(8'h00, 1'b0);
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  task automatic test_corner_cases();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_PORTRAIT, 13'd0);
    // drain with no frame waiting
    send_item(KIND_DRAIN, 8'h00);
    // drain in mid frame, then a write to an unmapped index
    repeat (9) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    send_item(KIND_DRAIN, 8'hFF);
    write_reg(REG_UNUSED, 13'h1FFF);
    while (!frame_complete()) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    // bytes after the frame are ignored until the drain ends it
    repeat (3) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    while (frame_complete()) send_item(KIND_DRAIN, 8'h5A);
    // register write aborts a partial frame
    repeat (11) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    write_reg(REG_PORTRAIT, 13'd1);
    run_frame(FILL_RANDOM, 1'b0);
    // sizes below the minimum clamp to two
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    run_frame(FILL_RANDOM, 1'b0);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_PORTRAIT, 13'd0);
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned first_item;
    first_item = items_taken;
    while (items_taken - first_item < RANDOM_ITEMS) begin
      stall_mode = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 3) == 0)
                                   ? CFG_W'($urandom_range(0, 15))
                                   : CFG_W'(4 * $urandom_range(1, 4)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 5)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_PORTRAIT, CFG_W'($urandom_range(0, 8191)));
      if ($urandom_range(0, 15) == 0) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 8191)));
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6))
             send_item(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
        1: repeat ($urandom_range(1, 20))
             send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
        default: run_frame(FILL_RANDOM, 1'b1);
      endcase
    end
  endtask

  // beyond-range sizes clamp to the maximum: a wide line start, then a tall
  // narrow frame in portrait
  task automatic test_size_limits();
    stall_mode = 1'b0;
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_PORTRAIT, 13'd0);
    repeat (LIMIT_PROBE_BYTES) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(REG_PORTRAIT, 13'd1);
    repeat (LIMIT_PROBE_BYTES) send_item(KIND_RAW, PIX_W'($urandom_range(0, 255)));
    stall_mode = 1'b1;
  endtask

  function automatic void check_field(string name, logic [DEST_W-1:0] want,
                                      logic [DEST_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      pixel_errors++;
    end
  endfunction

  // result side: random stalls on ready, one draw per transfer
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = stall_mode ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // compare each pixel transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: col %0d row %0d", out_ch.dest_col, out_ch.dest_row);
        pixel_errors++;
      end else begin
        want_px = pending_pixels.pop_front();
        check_field("red", want_px.red, out_ch.red);
        check_field("green", want_px.green, out_ch.green);
        check_field("blue", want_px.blue, out_ch.blue);
        check_field("dest_col", want_px.dest_col, out_ch.dest_col);
        check_field("dest_row", want_px.dest_row, out_ch.dest_row);
        check_field("frame_done", want_px.frame_done, out_ch.frame_done);
        check_field("run_last", want_px.run_last, out_ch.run_last);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_RAW;
    in_ch.raw_byte <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_FRAME_WIDTH;
    cfg_data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_min_frames();
    test_corner_cases();
    test_random_frames();
    test_size_limits();
    settle();
    if (pixel_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rbdm_pkg.sv
rtl/rbdm_if.sv
rtl/rbdm_line_store.sv
rtl/rbdm_demosaic.sv
rtl/raw10_bayer_demosaic_rgb_core.sv
verif/raw10_bayer_demosaic_rgb_core_tb.sv
